/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the homing sequencer core (lshs_core).
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define LSHS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define LSHS_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/lshs_pkg.sv */
package lshs_pkg;

	// Configuration register file geometry
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned ELAPSED_W = 17;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_SPEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_TIMEOUT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS      = 3'd7;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_FAST_SPEED    = 16'd1000;
	localparam logic [CFG_W-1:0] RST_SLOW_SPEED    = 16'd500;
	localparam logic [CFG_W-1:0] RST_BACKOFF_SPEED = 16'd500;
	localparam logic [CFG_W-1:0] RST_FAST_TIMEOUT  = 16'd30000;
	localparam logic [CFG_W-1:0] RST_SLOW_TIMEOUT  = 16'd15000;
	localparam logic [CFG_W-1:0] RST_BACKOFF_MS    = 16'd800;
	localparam logic [CFG_W-1:0] RST_SETTLE_MS     = 16'd500;
	localparam logic [CFG_W-1:0] RST_PAUSE_MS      = 16'd300;

	// Opcodes of an input item
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_ABORT = 2'd2;

	// Outcome codes
	localparam logic [2:0] OUT_NONE    = 3'd0;
	localparam logic [2:0] OUT_SUCCESS = 3'd1;
	localparam logic [2:0] OUT_FAST_TO = 3'd2;
	localparam logic [2:0] OUT_SLOW_TO = 3'd3;
	localparam logic [2:0] OUT_ABORT   = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_FAST    = 3'd1,
		PH_SETTLE  = 3'd2,
		PH_BACKOFF = 3'd3,
		PH_PAUSE   = 3'd4,
		PH_SLOW    = 3'd5
	} phase_t;

	// Register file contents as seen by the sequencer
	typedef struct packed {
		logic [CFG_W-1:0] fast_speed;
		logic [CFG_W-1:0] slow_speed;
		logic [CFG_W-1:0] backoff_speed;
		logic [CFG_W-1:0] fast_timeout_ms;
		logic [CFG_W-1:0] slow_timeout_ms;
		logic [CFG_W-1:0] backoff_ms;
		logic [CFG_W-1:0] settle_ms;
		logic [CFG_W-1:0] pause_ms;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic             motor_run;
		logic             motor_dir;
		logic [CFG_W-1:0] motor_speed;
		logic             clear_position;
		logic             busy_res;
		logic             homed;
		logic [2:0]       phase_now;
		logic [2:0]       outcome;
	} res_t;

	// Entering a timed phase with a zero count falls through to the next one
	function automatic phase_t phase_skip(phase_t p, cfg_t c);
		phase_t r;
		r = p;
		if (r == PH_SETTLE && c.settle_ms == '0) begin
			r = PH_BACKOFF;
		end
		if (r == PH_BACKOFF && c.backoff_ms == '0) begin
			r = PH_PAUSE;
		end
		if (r == PH_PAUSE && c.pause_ms == '0) begin
			r = PH_SLOW;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/lshs_cfg.sv */
// Configuration register file, write only
module lshs_cfg
	import lshs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_speed      <= RST_FAST_SPEED;
			cfg_q.slow_speed      <= RST_SLOW_SPEED;
			cfg_q.backoff_speed   <= RST_BACKOFF_SPEED;
			cfg_q.fast_timeout_ms <= RST_FAST_TIMEOUT;
			cfg_q.slow_timeout_ms <= RST_SLOW_TIMEOUT;
			cfg_q.backoff_ms      <= RST_BACKOFF_MS;
			cfg_q.settle_ms       <= RST_SETTLE_MS;
			cfg_q.pause_ms        <= RST_PAUSE_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FAST_SPEED:    cfg_q.fast_speed      <= cfg_data;
				REG_SLOW_SPEED:    cfg_q.slow_speed      <= cfg_data;
				REG_BACKOFF_SPEED: cfg_q.backoff_speed   <= cfg_data;
				REG_FAST_TIMEOUT:  cfg_q.fast_timeout_ms <= cfg_data;
				REG_SLOW_TIMEOUT:  cfg_q.slow_timeout_ms <= cfg_data;
				REG_BACKOFF_MS:    cfg_q.backoff_ms      <= cfg_data;
				REG_SETTLE_MS:     cfg_q.settle_ms       <= cfg_data;
				REG_PAUSE_MS:      cfg_q.pause_ms        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/lshs_core.sv */
`include "assert_macros.svh"

// Homing phase machine: state registers plus next-state and result logic
module lshs_core
	import lshs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] opcode,
	input  logic       switch_low,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t                 phase_q, phase_d;
	logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
	logic                   homed_q, homed_d;
	logic [2:0]             outcome_q, outcome_d;
	logic                   clr;
	logic                   pressed;
	logic [ELAPSED_W-1:0]   elapsed_inc;
	logic [CFG_W-1:0]       timed_len;

	assign pressed     = !switch_low;
	assign elapsed_inc = elapsed_q + 1'b1;

	// Length of the current timed phase
	always_comb begin
		unique case (phase_q)
			PH_SETTLE:  timed_len = cfg.settle_ms;
			PH_BACKOFF: timed_len = cfg.backoff_ms;
			default:    timed_len = cfg.pause_ms;
		endcase
	end

	// Next state
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		homed_d   = homed_q;
		outcome_d = outcome_q;
		clr       = 1'b0;
		case (opcode)
			OP_START: begin
				if (phase_q == PH_IDLE) begin
					homed_d   = 1'b0;
					outcome_d = OUT_NONE;
					phase_d   = PH_FAST;
					elapsed_d = '0;
				end
			end
			OP_ABORT: begin
				if (phase_q != PH_IDLE) begin
					phase_d   = PH_IDLE;
					elapsed_d = '0;
					outcome_d = OUT_ABORT;
				end
			end
			OP_TICK: begin
				unique case (phase_q)
					PH_FAST: begin
						if (pressed) begin
							phase_d   = phase_skip(PH_SETTLE, cfg);
							elapsed_d = '0;
						end else if (elapsed_inc > {1'b0, cfg.fast_timeout_ms}) begin
							phase_d   = PH_IDLE;
							elapsed_d = '0;
							outcome_d = OUT_FAST_TO;
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
					PH_SLOW: begin
						if (pressed) begin
							phase_d   = PH_IDLE;
							elapsed_d = '0;
							outcome_d = OUT_SUCCESS;
							homed_d   = 1'b1;
							clr       = 1'b1;
						end else if (elapsed_inc > {1'b0, cfg.slow_timeout_ms}) begin
							phase_d   = PH_IDLE;
							elapsed_d = '0;
							outcome_d = OUT_SLOW_TO;
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
					PH_SETTLE, PH_BACKOFF, PH_PAUSE: begin
						if (elapsed_inc >= {1'b0, timed_len}) begin
							elapsed_d = '0;
							unique case (phase_q)
								PH_SETTLE:  phase_d = phase_skip(PH_BACKOFF, cfg);
								PH_BACKOFF: phase_d = phase_skip(PH_PAUSE, cfg);
								default:    phase_d = PH_SLOW;
							endcase
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Result outputs, taken after the update
	always_comb begin
		res                = '0;
		res.clear_position = clr;
		res.busy_res       = (phase_d != PH_IDLE);
		res.homed          = homed_d;
		res.phase_now      = phase_d;
		res.outcome        = outcome_d;
		unique case (phase_d)
			PH_FAST: begin
				res.motor_run   = 1'b1;
				res.motor_speed = cfg.fast_speed;
			end
			PH_BACKOFF: begin
				res.motor_run   = 1'b1;
				res.motor_dir   = 1'b1;
				res.motor_speed = cfg.backoff_speed;
			end
			PH_SLOW: begin
				res.motor_run   = 1'b1;
				res.motor_speed = cfg.slow_speed;
			end
			default: ;
		endcase
	end

	// State registers advance once per transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			homed_q   <= 1'b0;
			outcome_q <= OUT_NONE;
		end else if (fire) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			homed_q   <= homed_d;
			outcome_q <= outcome_d;
		end
	end

	`LSHS_ASSERT(a_idle_no_count, phase_q == PH_IDLE |-> elapsed_q == '0, "elapsed nonzero while idle")
	`LSHS_ASSERT(a_clear_sets_homed, fire && clr |=> homed_q && phase_q == PH_IDLE && outcome_q == OUT_SUCCESS, "position clear without homed")
	`LSHS_ASSERT(a_start_enters_fast, fire && opcode == OP_START && phase_q == PH_IDLE |=> phase_q == PH_FAST && !homed_q, "start did not enter fast search")

endmodule

/* hw/rtl/limit_switch_homing_sequencer.sv */
// Two-pass limit switch homing sequencer. Each input transfer is a 1 ms tick,
// a start or an abort, carrying the active-low switch level; each one yields
// exactly one result transfer with the motor command and status after it.
// An item passes an input register and then a result register; one item per
// cycle is sustained while out_stall is low: the phase machine and its 17-bit
// tick counter settle each item combinationally. Configuration must be written
// through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module limit_switch_homing_sequencer
	import lshs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic                 switch_low,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 motor_run,
	output logic                 motor_dir,
	output logic [CFG_W-1:0]     motor_speed,
	output logic                 clear_position,
	output logic                 busy_res,
	output logic                 homed,
	output logic [2:0]           phase_now,
	output logic [2:0]           outcome
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic       switch_low_s1;
	logic       out_free;
	logic       fire;

	// Pipeline control
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	lshs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lshs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.opcode     (opcode_s1),
		.switch_low (switch_low_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1     <= opcode;
			switch_low_s1 <= switch_low;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign motor_run      = res_q.motor_run;
	assign motor_dir      = res_q.motor_dir;
	assign motor_speed    = res_q.motor_speed;
	assign clear_position = res_q.clear_position;
	assign busy_res       = res_q.busy_res;
	assign homed          = res_q.homed;
	assign phase_now      = res_q.phase_now;
	assign outcome        = res_q.outcome;

endmodule

/* test/limit_switch_homing_sequencer_tb.sv */
module limit_switch_homing_sequencer_tb;
	import lshs_pkg::*;

	// Opcode three has no meaning in the block and must act as a no-op
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] op;
		logic       sw;
	} cmd_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode = OP_TICK;
	logic                 switch_low = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 motor_run;
	logic                 motor_dir;
	logic [CFG_W-1:0]     motor_speed;
	logic                 clear_position;
	logic                 busy_res;
	logic                 homed;
	logic [2:0]           phase_now;
	logic [2:0]           outcome;

	limit_switch_homing_sequencer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.switch_low     (switch_low),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_run      (motor_run),
		.motor_dir      (motor_dir),
		.motor_speed    (motor_speed),
		.clear_position (clear_position),
		.busy_res       (busy_res),
		.homed          (homed),
		.phase_now      (phase_now),
		.outcome        (outcome)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the sequencer: registers, phase, tick count, flags
	logic [CFG_W-1:0]     cfg_shadow [NUM_REGS];
	phase_t               seq_phase;
	logic [ELAPSED_W-1:0] seq_elapsed;
	logic                 seq_homed;
	logic [2:0]           seq_outcome;

	cmd_t pending_cmds [$];
	res_t status_expect [$];

	int pushed_cnt = 0;
	int taken_cnt = 0;
	int results_seen = 0;
	int errors = 0;
	int settings_used = 0;
	int abort_in = 0;
	int outcome_tally [0:4] = '{0, 0, 0, 0, 0};
	int cycle_cnt = 0;

	function automatic logic [CFG_W-1:0] timed_len(phase_t p);
		case (p)
			PH_SETTLE: return cfg_shadow[REG_SETTLE_MS];
			PH_BACKOFF: return cfg_shadow[REG_BACKOFF_MS];
			default: return cfg_shadow[REG_PAUSE_MS];
		endcase
	endfunction

	// Entering a timed phase of zero length falls straight through
	task automatic enter_phase(phase_t p);
		seq_phase = p;
		seq_elapsed = '0;
		while ((seq_phase == PH_SETTLE || seq_phase == PH_BACKOFF || seq_phase == PH_PAUSE)
				&& timed_len(seq_phase) == '0) begin
			seq_phase = phase_t'(seq_phase + 3'd1);
		end
	endtask

	task automatic conclude(logic [2:0] code);
		seq_phase = PH_IDLE;
		seq_elapsed = '0;
		seq_outcome = code;
		outcome_tally[code]++;
	endtask

	// Advance the shadow by one transfer and queue the status it must produce
	task automatic step_homing(input logic [1:0] op, input logic sw);
		res_t r;
		logic pressed;
		r = '0;
		pressed = (sw == 1'b0);
		case (op)
			OP_START: begin
				if (seq_phase == PH_IDLE) begin
					seq_homed = 1'b0;
					seq_outcome = OUT_NONE;
					enter_phase(PH_FAST);
				end
			end
			OP_ABORT: begin
				if (seq_phase != PH_IDLE) begin
					conclude(OUT_ABORT);
				end
			end
			OP_TICK: begin
				if (seq_phase == PH_FAST || seq_phase == PH_SLOW) begin
					if (pressed && seq_phase == PH_FAST) begin
						enter_phase(PH_SETTLE);
					end else if (pressed) begin
						conclude(OUT_SUCCESS);
						seq_homed = 1'b1;
						r.clear_position = 1'b1;
					end else begin
						seq_elapsed++;
						if (seq_phase == PH_FAST
								&& seq_elapsed > {1'b0, cfg_shadow[REG_FAST_TIMEOUT]}) begin
							conclude(OUT_FAST_TO);
						end else if (seq_phase == PH_SLOW
								&& seq_elapsed > {1'b0, cfg_shadow[REG_SLOW_TIMEOUT]}) begin
							conclude(OUT_SLOW_TO);
						end
					end
				end else if (seq_phase != PH_IDLE) begin
					seq_elapsed++;
					if (seq_elapsed >= {1'b0, timed_len(seq_phase)}) begin
						enter_phase(phase_t'(seq_phase + 3'd1));
					end
				end
			end
			default: ;
		endcase

		// Motor command follows the phase after the update
		case (seq_phase)
			PH_FAST: begin
				r.motor_run = 1'b1;
				r.motor_speed = cfg_shadow[REG_FAST_SPEED];
			end
			PH_BACKOFF: begin
				r.motor_run = 1'b1;
				r.motor_dir = 1'b1;
				r.motor_speed = cfg_shadow[REG_BACKOFF_SPEED];
			end
			PH_SLOW: begin
				r.motor_run = 1'b1;
				r.motor_speed = cfg_shadow[REG_SLOW_SPEED];
			end
			default: ;
		endcase
		r.busy_res = (seq_phase != PH_IDLE);
		r.homed = seq_homed;
		r.phase_now = seq_phase;
		r.outcome = seq_outcome;
		status_expect.push_back(r);
	endtask

	task automatic check_field(string name, logic [CFG_W-1:0] want, logic [CFG_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Driver: offers queued commands with random gaps, predicts on each transfer
	int gap_left = 0;
	int send_calm = 0;
	always @(posedge clk) begin : driver
		cmd_t nxt;
		int r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				step_homing(opcode, switch_low);
				taken_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					nxt = pending_cmds.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.op;
					switch_low <= nxt.sw;
					if (send_calm != 0) begin
						send_calm--;
					end else begin
						r = $urandom_range(0, 99);
						if (r < 2) begin
							send_calm = $urandom_range(20, 80);
						end else if (r < 5) begin
							gap_left = $urandom_range(10, 40);
						end else if (r < 30) begin
							gap_left = $urandom_range(1, 3);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer, stalls at random, holds off long now and then
	int hold_left = 0;
	int recv_calm = 0;
	always @(posedge clk) begin : monitor
		res_t want;
		int r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (status_expect.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected", $time);
				end else begin
					want = status_expect.pop_front();
					check_field("motor_run", CFG_W'(want.motor_run), CFG_W'(motor_run));
					check_field("motor_dir", CFG_W'(want.motor_dir), CFG_W'(motor_dir));
					check_field("motor_speed", want.motor_speed, motor_speed);
					check_field("clear_position", CFG_W'(want.clear_position),
						CFG_W'(clear_position));
					check_field("busy_res", CFG_W'(want.busy_res), CFG_W'(busy_res));
					check_field("homed", CFG_W'(want.homed), CFG_W'(homed));
					check_field("phase_now", CFG_W'(want.phase_now), CFG_W'(phase_now));
					check_field("outcome", CFG_W'(want.outcome), CFG_W'(outcome));
				end
				results_seen++;
				// long hold-off so the block backs up and stalls its input
				if (results_seen % 250 == 100) begin
					hold_left = 120;
				end
			end
			if (hold_left == 0) begin
				if (recv_calm != 0) begin
					recv_calm--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						recv_calm = $urandom_range(30, 120);
					end else if (r < 6) begin
						hold_left = $urandom_range(10, 30);
					end else if (r < 30) begin
						hold_left = $urandom_range(1, 3);
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("limit_switch_homing_sequencer_tb failed");
			$finish;
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic sw);
		cmd_t c;
		c.op = op;
		c.sw = sw;
		pending_cmds.push_back(c);
		pushed_cnt++;
	endtask

	// Command inside a homing sequence, with occasional stray start or no-op and a
	// pending abort counted down
	task automatic add_cmd(input logic [1:0] op, input logic sw);
		push_cmd(op, sw);
		if ($urandom_range(0, 99) < 4) begin
			push_cmd($urandom_range(0, 1) ? OP_START : OP_NOP, 1'($urandom_range(0, 1)));
		end
		if (abort_in != 0) begin
			abort_in--;
			if (abort_in == 0) begin
				push_cmd(OP_ABORT, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic wait_idle();
		while (taken_cnt != pushed_cnt || status_expect.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Write all eight registers while the block is idle
	task automatic set_config(input logic [CFG_W-1:0] fs, ss, bs, fto, sto, bms, sms, pms);
		logic [CFG_W-1:0] v [NUM_REGS];
		v = '{fs, ss, bs, fto, sto, bms, sms, pms};
		for (int i = 0; i < NUM_REGS; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= v[i];
			cfg_shadow[i] = v[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	// Mostly complete homing runs with random search lengths; some plain noise
	task automatic homing_batch(int quota);
		int first;
		int fto;
		int sto;
		int n;
		first = pushed_cnt;
		fto = int'(cfg_shadow[REG_FAST_TIMEOUT]);
		sto = int'(cfg_shadow[REG_SLOW_TIMEOUT]);
		while (pushed_cnt - first < quota) begin
			if ($urandom_range(0, 99) < 80) begin
				abort_in = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0;
				add_cmd(OP_START, 1'($urandom_range(0, 1)));
				n = $urandom_range(0, ((fto > 12) ? 12 : fto) + 1);
				repeat (n) add_cmd(OP_TICK, 1'b1);
				if (n <= fto) begin
					add_cmd(OP_TICK, 1'b0);
					n = int'(cfg_shadow[REG_SETTLE_MS]) + int'(cfg_shadow[REG_BACKOFF_MS])
						+ int'(cfg_shadow[REG_PAUSE_MS]);
					repeat (n) add_cmd(OP_TICK, 1'($urandom_range(0, 1)));
					n = $urandom_range(0, ((sto > 12) ? 12 : sto) + 1);
					repeat (n) add_cmd(OP_TICK, 1'b1);
					if (n <= sto) begin
						add_cmd(OP_TICK, 1'b0);
					end
				end
				abort_in = 0;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					push_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		cfg_shadow = '{RST_FAST_SPEED, RST_SLOW_SPEED, RST_BACKOFF_SPEED, RST_FAST_TIMEOUT,
			RST_SLOW_TIMEOUT, RST_BACKOFF_MS, RST_SETTLE_MS, RST_PAUSE_MS};
		seq_phase = PH_IDLE;
		seq_elapsed = '0;
		seq_homed = 1'b0;
		seq_outcome = OUT_NONE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: idle commands, ignored start, abort mid-sequence
		push_cmd(OP_TICK, 1'b1);
		push_cmd(OP_ABORT, 1'b0);
		push_cmd(OP_NOP, 1'b0);
		push_cmd(OP_START, 1'b1);
		push_cmd(OP_START, 1'b0);
		push_cmd(OP_TICK, 1'b1);
		push_cmd(OP_TICK, 1'b0);
		push_cmd(OP_NOP, 1'b1);
		push_cmd(OP_ABORT, 1'b1);
		push_cmd(OP_TICK, 1'b0);
		wait_idle();

		// Short timings: one full success, then a fast-search timeout
		set_config(16'hA5A5, 16'h5A5A, 16'h0001, 16'd2, 16'd2, 16'd1, 16'd1, 16'd1);
		push_cmd(OP_START, 1'b1);
		push_cmd(OP_TICK, 1'b1);
		push_cmd(OP_TICK, 1'b0);
		repeat (3) push_cmd(OP_TICK, 1'b1);
		push_cmd(OP_TICK, 1'b0);
		push_cmd(OP_START, 1'b0);
		repeat (3) push_cmd(OP_TICK, 1'b1);
		push_cmd(OP_ABORT, 1'b0);
		homing_batch(130);
		wait_idle();

		// All zero: timed phases skipped, zero timeouts, zero speeds
		set_config('0, '0, '0, '0, '0, '0, '0, '0);
		homing_batch(130);
		wait_idle();

		// Largest speeds and timeouts
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 3)),
			CFG_W'($urandom_range(0, 3)));
		homing_batch(130);
		wait_idle();

		// Random settings with short timings
		repeat (3) begin
			set_config(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
				CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 10)),
				CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 4)),
				CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)));
			homing_batch(150);
			wait_idle();
		end

		$display("Checked %0d transfers over %0d register settings, switch pressed and released.",
			taken_cnt, settings_used);
		$display("Sequences ended: %0d homed, %0d fast timeout, %0d slow timeout, %0d aborted.",
			outcome_tally[OUT_SUCCESS], outcome_tally[OUT_FAST_TO], outcome_tally[OUT_SLOW_TO],
			outcome_tally[OUT_ABORT]);
		if (errors == 0) begin
			$display("limit_switch_homing_sequencer_tb passed");
		end else begin
			$display("limit_switch_homing_sequencer_tb failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/lshs_pkg.sv
hw/rtl/lshs_cfg.sv
hw/rtl/lshs_core.sv
hw/rtl/limit_switch_homing_sequencer.sv
test/limit_switch_homing_sequencer_tb.sv
